// ===== rtl/spherical_to_cartesian_ecef_top_defines.svh =====
// Assertion macros for the spherical-to-Cartesian converter.
// Used by the top level only; no other dependencies.
`ifndef SPHERICAL_TO_CARTESIAN_ECEF_TOP_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_ECEF_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define S2C_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("s2c assertion failed");
`define S2C_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("s2c reset assertion failed");
`else
`define S2C_ASSERT(label, prop)
`define S2C_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/s2c_pkg.sv =====
// Shared widths, constants and the arctangent table of the converter.
// No dependencies.
package s2c_pkg;
    localparam int ANG_W = 32;
    localparam int LEN_W = 34;
    localparam int RAD_W = 31;
    localparam int Z_W   = 34;
    localparam int CS_W  = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam logic signed [Z_W-1:0]   HALF_PI = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]   PI_Q30  = 34'sd3373259426;
    localparam logic signed [CS_W-1:0]  GAIN    = 32'sd652032874;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 31'd1630976000;
    localparam logic signed [LEN_W-1:0] OUT_LIMIT = 34'sd4294967296;

    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = (i < 31) ? (Z_W'(1) <<< (30 - i)) : '0;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/spherical_to_cartesian_ecef_top.sv =====
// Top level of the spherical-to-Cartesian converter.
// Depends on s2c_pkg, s2c_prep, s2c_cordic, s2c_mul and the defines header.
//
//   channel  direction  handshake                 word
//   in       sink       i_in_valid / o_in_stall   longitude, colatitude, altitude
//   out      source     o_out_valid / i_out_stall pos_x, pos_y, pos_z
//   cfg      sink       i_cfg_valid / o_cfg_ready earth_radius
//
// One word enters per cycle while the pipeline is not frozen; it has one input
// stage, one per CORDIC iteration, and four product and rounding stages.
// The whole pipeline advances together; it freezes only while a finished word
// waits at the output under stall, and bubbles move on otherwise.
// Reset clears the valid bits and loads the default radius.
`include "spherical_to_cartesian_ecef_top_defines.svh"
module spherical_to_cartesian_ecef_top #(
    parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_longitude,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_colatitude,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_altitude,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_x,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_y,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [s2c_pkg::RAD_W-1:0]         i_cfg_data
);
    import s2c_pkg::*;

    localparam int LAT = CORDIC_STAGES + 5;

    logic                    w_en;
    logic [RAD_W-1:0]        r_earth_radius;
    logic [LAT-1:0]          r_vld;
    logic signed [Z_W-1:0]   w_z_lon, w_z_col;
    logic                    w_f_lon, w_f_col;
    logic signed [LEN_W-1:0] w_r;
    logic signed [LEN_W-1:0] r_rdly [CORDIC_STAGES];
    logic signed [CS_W-1:0]  w_sl, w_cl, w_sc, w_cc;

    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earth_radius <= RADIUS_RESET;
            r_vld          <= '0;
        end else begin
            if (i_cfg_valid)
                r_earth_radius <= i_cfg_data;
            if (w_en)
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    s2c_prep u_prep (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_longitude  (i_longitude),
        .i_colatitude (i_colatitude),
        .i_altitude   (i_altitude),
        .i_radius     (r_earth_radius),
        .o_z_lon      (w_z_lon),
        .o_flip_lon   (w_f_lon),
        .o_z_col      (w_z_col),
        .o_flip_col   (w_f_col),
        .o_r          (w_r)
    );

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_z    (w_z_lon),
        .i_flip (w_f_lon),
        .o_sin  (w_sl),
        .o_cos  (w_cl)
    );

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_col (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_z    (w_z_col),
        .i_flip (w_f_col),
        .o_sin  (w_sc),
        .o_cos  (w_cc)
    );

    // carry the radius alongside the CORDIC stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rdly[0] <= w_r;
            for (int k = 1; k < CORDIC_STAGES; k++)
                r_rdly[k] <= r_rdly[k-1];
        end
    end

    s2c_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_r       (r_rdly[CORDIC_STAGES-1]),
        .i_sin_lon (w_sl),
        .i_cos_lon (w_cl),
        .i_sin_col (w_sc),
        .i_cos_col (w_cc),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z)
    );

    `S2C_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_out_valid)
    `S2C_ASSERT(a_freeze_holds, o_out_valid && i_out_stall |=> $stable(r_vld))
    `S2C_ASSERT(a_z_bound, o_out_valid |-> o_pos_z <= OUT_LIMIT && o_pos_z >= -OUT_LIMIT)
endmodule

// ===== rtl/s2c_prep.sv =====
// Input stage: angle widening and half-turn folding, radius sum.
// Depends on s2c_pkg.
module s2c_prep (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_longitude,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_colatitude,
    input  logic signed [s2c_pkg::ANG_W-1:0]  i_altitude,
    input  logic [s2c_pkg::RAD_W-1:0]         i_radius,
    output logic signed [s2c_pkg::Z_W-1:0]    o_z_lon,
    output logic                              o_flip_lon,
    output logic signed [s2c_pkg::Z_W-1:0]    o_z_col,
    output logic                              o_flip_col,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_r
);
    import s2c_pkg::*;

    logic signed [Z_W-1:0]   w_zl, w_zc, n_zl, n_zc, r_zl, r_zc;
    logic                    n_fl, n_fc, r_fl, r_fc;
    logic signed [LEN_W-1:0] n_r, r_r;

    assign w_zl = Z_W'(i_longitude) <<< 1;
    assign w_zc = Z_W'(i_colatitude) <<< 1;

    // fold beyond a quarter turn; sine and cosine flip sign later
    always_comb begin
        n_zl = w_zl;
        n_fl = 1'b0;
        if (w_zl > HALF_PI) begin
            n_zl = w_zl - PI_Q30;
            n_fl = 1'b1;
        end else if (w_zl < -HALF_PI) begin
            n_zl = w_zl + PI_Q30;
            n_fl = 1'b1;
        end
        n_zc = w_zc;
        n_fc = 1'b0;
        if (w_zc > HALF_PI) begin
            n_zc = w_zc - PI_Q30;
            n_fc = 1'b1;
        end else if (w_zc < -HALF_PI) begin
            n_zc = w_zc + PI_Q30;
            n_fc = 1'b1;
        end
        n_r = LEN_W'(i_altitude) + $signed({{(LEN_W-RAD_W){1'b0}}, i_radius});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zl <= n_zl;
            r_fl <= n_fl;
            r_zc <= n_zc;
            r_fc <= n_fc;
            r_r  <= n_r;
        end
    end

    assign o_z_lon    = r_zl;
    assign o_flip_lon = r_fl;
    assign o_z_col    = r_zc;
    assign o_flip_col = r_fc;
    assign o_r        = r_r;
endmodule

// ===== rtl/s2c_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// Depends on s2c_pkg.
module s2c_cordic #(
    parameter int STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [s2c_pkg::Z_W-1:0]    i_z,
    input  logic                              i_flip,
    output logic signed [s2c_pkg::CS_W-1:0]   o_sin,
    output logic signed [s2c_pkg::CS_W-1:0]   o_cos
);
    import s2c_pkg::*;

    logic signed [CS_W-1:0] r_x [STAGES];
    logic signed [CS_W-1:0] r_y [STAGES];
    logic signed [Z_W-1:0]  r_z [STAGES];
    logic                   r_f [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CS_W-1:0] w_xi, w_yi, n_x, n_y;
        logic signed [Z_W-1:0]  w_zi, n_z;
        logic                   w_fi;

        if (k == 0) begin : g_first
            assign w_xi = GAIN;
            assign w_yi = '0;
            assign w_zi = i_z;
            assign w_fi = i_flip;
        end else begin : g_next
            assign w_xi = r_x[k-1];
            assign w_yi = r_y[k-1];
            assign w_zi = r_z[k-1];
            assign w_fi = r_f[k-1];
        end

        always_comb begin
            if (w_zi >= 0) begin
                n_x = w_xi - (w_yi >>> k);
                n_y = w_yi + (w_xi >>> k);
                n_z = w_zi - atan_q30(k);
            end else begin
                n_x = w_xi + (w_yi >>> k);
                n_y = w_yi - (w_xi >>> k);
                n_z = w_zi + atan_q30(k);
            end
            // undo the half-turn fold on the last iteration
            if (k == STAGES - 1 && w_fi) begin
                n_x = -n_x;
                n_y = -n_y;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
                r_f[k] <= w_fi;
            end
        end
    end

    assign o_cos = r_x[STAGES-1];
    assign o_sin = r_y[STAGES-1];
endmodule

// ===== rtl/s2c_mul.sv =====
// Product stages: r times the longitude terms and cos(colat), then x and y times sin(colat).
// Each product rounds half up to Q8; the final words saturate. Depends on s2c_pkg.
module s2c_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [s2c_pkg::LEN_W-1:0]  i_r,
    input  logic signed [s2c_pkg::CS_W-1:0]   i_sin_lon,
    input  logic signed [s2c_pkg::CS_W-1:0]   i_cos_lon,
    input  logic signed [s2c_pkg::CS_W-1:0]   i_sin_col,
    input  logic signed [s2c_pkg::CS_W-1:0]   i_cos_col,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_x,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_y,
    output logic signed [s2c_pkg::LEN_W-1:0]  o_pos_z
);
    import s2c_pkg::*;

    localparam int P_W  = LEN_W + CS_W;
    localparam int RC_W = P_W - 30;
    localparam int Q_W  = RC_W + CS_W;
    localparam int V_W  = Q_W - 30;

    logic signed [P_W-1:0]  r_pc, r_ps, r_pz;
    logic signed [CS_W-1:0] r_sc_a, r_sc_b;
    logic signed [RC_W-1:0] r_rc, r_rs, r_z_b, r_z_c;
    logic signed [Q_W-1:0]  r_qx, r_qy;
    logic signed [LEN_W-1:0] r_x, r_y, r_z;
    logic signed [V_W-1:0]  w_vx, w_vy, w_vz;

    function automatic logic signed [LEN_W-1:0] sat(input logic signed [V_W-1:0] v);
        logic signed [LEN_W-1:0] o;
        if (v > V_W'(OUT_LIMIT))
            o = OUT_LIMIT;
        else if (v < -V_W'(OUT_LIMIT))
            o = -OUT_LIMIT;
        else
            o = LEN_W'(v);
        return o;
    endfunction

    assign w_vx = V_W'((r_qx + (Q_W'(1) <<< 29)) >>> 30);
    assign w_vy = V_W'((r_qy + (Q_W'(1) <<< 29)) >>> 30);
    assign w_vz = V_W'(r_z_c);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc   <= P_W'(i_r) * P_W'(i_cos_lon);
            r_ps   <= P_W'(i_r) * P_W'(i_sin_lon);
            r_pz   <= P_W'(i_r) * P_W'(i_cos_col);
            r_sc_a <= i_sin_col;

            r_rc   <= RC_W'((r_pc + (P_W'(1) <<< 29)) >>> 30);
            r_rs   <= RC_W'((r_ps + (P_W'(1) <<< 29)) >>> 30);
            r_z_b  <= RC_W'((r_pz + (P_W'(1) <<< 29)) >>> 30);
            r_sc_b <= r_sc_a;

            r_qx   <= Q_W'(r_rc) * Q_W'(r_sc_b);
            r_qy   <= Q_W'(r_rs) * Q_W'(r_sc_b);
            r_z_c  <= r_z_b;

            r_x    <= sat(w_vx);
            r_y    <= sat(w_vy);
            r_z    <= sat(w_vz);
        end
    end

    assign o_pos_x = r_x;
    assign o_pos_y = r_y;
    assign o_pos_z = r_z;
endmodule

// ===== tb/sv/spherical_to_cartesian_ecef_top_tb.sv =====
// Self-checking testbench for the spherical-to-Cartesian converter top level.
// Depends on s2c_pkg and spherical_to_cartesian_ecef_top; drives positions with
// random idling and stalls and checks x, y, z against a built-in predictor.
module spherical_to_cartesian_ecef_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import s2c_pkg::*;

    localparam int STAGES  = CORDIC_STAGES_DEF;
    localparam int LATENCY = STAGES + 5;
    localparam int N_RAND  = 1450;

    typedef struct packed {
        logic signed [LEN_W-1:0] x;
        logic signed [LEN_W-1:0] y;
        logic signed [LEN_W-1:0] z;
    } t_ecef;

    typedef struct {
        logic signed [ANG_W-1:0] lon;
        logic signed [ANG_W-1:0] col;
        logic signed [ANG_W-1:0] alt;
        bit                      known;
        t_ecef                   pos;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [ANG_W-1:0] i_longitude = '0;
    logic signed [ANG_W-1:0] i_colatitude = '0;
    logic signed [ANG_W-1:0] i_altitude = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [LEN_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [RAD_W-1:0]        i_cfg_data = '0;

    spherical_to_cartesian_ecef_top #(.CORDIC_STAGES(STAGES)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("** spherical_to_cartesian_ecef_top: FAILED **");
        $finish;
    end

    logic [RAD_W-1:0] radius = RADIUS_RESET;
    t_ecef            pending_pos[$];
    int               mismatches = 0;
    bit               calm = 1'b0;
    int               hold_off = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return t[i];
        if (i < 31) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    function automatic void rotate_angle(longint q329, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z = q329 * 2;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI) begin
            z -= PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI) begin
            z += PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab(i);
            end else begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic logic signed [LEN_W-1:0] clamp_len(longint v);
        if (v > 64'sd4294967296) v = 64'sd4294967296;
        if (v < -64'sd4294967296) v = -64'sd4294967296;
        return v[LEN_W-1:0];
    endfunction

    function automatic t_ecef convert_position(logic signed [ANG_W-1:0] lon,
                                               logic signed [ANG_W-1:0] col,
                                               logic signed [ANG_W-1:0] alt);
        longint sl, cl, sc, cc, r;
        t_ecef  p;
        r = longint'(alt) + longint'(radius);
        rotate_angle(lon, sl, cl);
        rotate_angle(col, sc, cc);
        p.x = clamp_len(round_q30(round_q30(r, cl), sc));
        p.y = clamp_len(round_q30(round_q30(r, sl), sc));
        p.z = clamp_len(round_q30(r, cc));
        return p;
    endfunction

    // Receiver: random stall bursts, one long hold-off when requested.
    initial begin
        int burst;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 9);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Check each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        t_ecef want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word x=%0d", o_pos_x);
            end else begin
                want = pending_pos.pop_front();
                if (want.x !== o_pos_x || want.y !== o_pos_y || want.z !== o_pos_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 want.x, want.y, want.z, o_pos_x, o_pos_y, o_pos_z);
                end
            end
        end
    end

    task automatic send_word(logic signed [ANG_W-1:0] lon, logic signed [ANG_W-1:0] col,
                             logic signed [ANG_W-1:0] alt, bit known, t_ecef pos);
        t_ecef p;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_longitude  <= lon;
        i_colatitude <= col;
        i_altitude   <= alt;
        p = convert_position(lon, col, alt);
        // Typed-in rows are checked against the table, the rest against the predictor.
        pending_pos.push_back(known ? pos : p);
        @(posedge i_clk iff !o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_pos.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RAD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius = value;
    endtask

    function automatic logic signed [ANG_W-1:0] rand_angle();
        return $signed($urandom_range(0, 32'd3373259426)) - 32'sd1686629713;
    endfunction

    localparam logic signed [ANG_W-1:0] HP = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] AMAX = 32'sd1686629713;

    t_stim_row directed[] = '{
        '{32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
        '{32'sd0, HP, 32'sd0, 1'b0, '0},
        '{HP, HP, 32'sd0, 1'b0, '0},
        '{-HP, -HP, 32'sd0, 1'b0, '0},
        '{AMAX, AMAX, 32'sd0, 1'b0, '0},
        '{-AMAX, -AMAX, 32'sd0, 1'b0, '0},
        '{HP + 32'sd1, HP - 32'sd1, 32'sd256, 1'b0, '0},
        '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0, '0},
        '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0, '0},
        '{32'sd12345678, 32'sd98765432, -32'sd1630976000, 1'b0, '0},
        '{32'sd0, 32'sd0, 32'sh80000000, 1'b0, '0},
        '{32'sd0, 32'sd0, 32'sd2147483647, 1'b0, '0},
        '{32'sd300000000, 32'sd700000000, -32'sd1700000000, 1'b0, '0},
        '{-32'sd1, 32'sd1, 32'sd1, 1'b0, '0},
        '{32'sd555555555, -32'sd1234567890, 32'sd1000000, 1'b0, '0}
    };

    initial begin
        logic [RAD_W-1:0] radii[4];
        t_ecef            none;
        none = '0;
        radii = '{31'h7fffffff, 31'd0, 31'd1630976000, 31'd0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_word(directed[k].lon, directed[k].col, directed[k].alt,
                      directed[k].known, directed[k].pos);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            radii[3] = RAD_W'($urandom_range(0, 32'h7fffffff));
            write_radius(radii[phase]);
            if (phase == 1) hold_off = 200;
            if (phase == 3) calm = 1'b1;
            for (int n = 0; n < N_RAND / 4; n++) begin
                send_word(rand_angle(), rand_angle(),
                          ($urandom_range(0, 3) == 0) ? $signed($urandom)
                                                      : $signed($urandom_range(0, 2000000000))
                                                        - 32'sd1000000000,
                          1'b0, none);
                if (phase == 2 && n == 100) drain();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** spherical_to_cartesian_ecef_top: PASSED **");
        end else begin
            $display("** spherical_to_cartesian_ecef_top: FAILED **");
        end
        $finish;
    end
endmodule
